// ----- rtl/core/mpfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Marker pose package
// Shared payload types, pipeline depths and the arctangent table used by the
// marker pose pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mpfc_pkg;

  // Default number of fraction bits of the unit normal components.
  localparam int NormalFracBitsDef = 14;

  // Heading CORDIC: vectoring steps and the register count of its pipeline
  // (magnitude search, normalizing shift, quarter turn, steps, rounding).
  localparam int CordicSteps = 30;
  localparam int CordicLat   = CordicSteps + 4;

  // Integer square root of a 64-bit value: one result bit per stage.
  localparam int SqrtSteps = 32;

  typedef struct packed {
    logic signed [31:0] c0_x;
    logic signed [31:0] c0_y;
    logic signed [31:0] c0_z;
    logic signed [31:0] c1_x;
    logic signed [31:0] c1_y;
    logic signed [31:0] c1_z;
    logic signed [31:0] c2_x;
    logic signed [31:0] c2_y;
    logic signed [31:0] c2_z;
    logic signed [31:0] c3_x;
    logic signed [31:0] c3_y;
    logic signed [31:0] c3_z;
  } pose_in_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] heading;
    logic               degenerate;
  } pose_out_t;

  // atan(2^-i) with 2^31 standing for pi.
  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] val;
    unique case (idx)
      5'd0:  val = 30'h20000000;
      5'd1:  val = 30'h12E4051E;
      5'd2:  val = 30'h09FB385B;
      5'd3:  val = 30'h051111D4;
      5'd4:  val = 30'h028B0D43;
      5'd5:  val = 30'h0145D7E1;
      5'd6:  val = 30'h00A2F61E;
      5'd7:  val = 30'h00517C55;
      5'd8:  val = 30'h0028BE53;
      5'd9:  val = 30'h00145F2F;
      5'd10: val = 30'h000A2F98;
      5'd11: val = 30'h000517CC;
      5'd12: val = 30'h00028BE6;
      5'd13: val = 30'h000145F3;
      5'd14: val = 30'h0000A2FA;
      5'd15: val = 30'h0000517D;
      5'd16: val = 30'h000028BE;
      5'd17: val = 30'h0000145F;
      5'd18: val = 30'h00000A30;
      5'd19: val = 30'h00000518;
      5'd20: val = 30'h0000028C;
      5'd21: val = 30'h00000146;
      5'd22: val = 30'h000000A3;
      5'd23: val = 30'h00000051;
      5'd24: val = 30'h00000029;
      5'd25: val = 30'h00000014;
      5'd26: val = 30'h0000000A;
      5'd27: val = 30'h00000005;
      5'd28: val = 30'h00000003;
      5'd29: val = 30'h00000001;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mpfc_cordic.sv -----
// ----------------------------------------------------------------------------
// Marker pose heading CORDIC
// Pipelined atan2 of an edge vector, one vectoring step per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfc_cordic (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [32:0] ex_i,
  input  wire logic signed [32:0] ey_i,
  output logic signed [15:0]      heading_o
);

  localparam int W  = 38;
  localparam int AW = 34;
  localparam int N  = mpfc_pkg::CordicSteps;

  // Magnitude search: shift so the larger magnitude lands in [2^33, 2^34).
  logic [32:0] ax, ay, am;
  logic [5:0]  blen;
  always_comb begin
    ax = ex_i[32] ? 33'(-ex_i) : 33'(ex_i);
    ay = ey_i[32] ? 33'(-ey_i) : 33'(ey_i);
    am = (ax > ay) ? ax : ay;
    blen = '0;
    for (int b = 0; b < 33; b++) begin
      if (am[b]) begin
        blen = 6'(b + 1);
      end
    end
  end

  logic signed [32:0] a_x_q, a_y_q;
  logic [5:0]         a_k_q;
  logic               a_zero_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_x_q    <= ex_i;
      a_y_q    <= ey_i;
      a_k_q    <= 6'd34 - blen;
      a_zero_q <= (am == '0);
    end
  end

  logic signed [W-1:0] b_x_q, b_y_q;
  logic                b_zero_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_x_q    <= W'(a_x_q) <<< a_k_q;
      b_y_q    <= W'(a_y_q) <<< a_k_q;
      b_zero_q <= a_zero_q;
    end
  end

  logic signed [W-1:0]  cx_q [N+1];
  logic signed [W-1:0]  cy_q [N+1];
  logic signed [AW-1:0] ca_q [N+1];
  logic                 cz_q [N+1];

  // Left half plane is first turned by a quarter turn.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cz_q[0] <= b_zero_q;
      if (b_x_q[W-1]) begin
        if (!b_y_q[W-1]) begin
          cx_q[0] <= b_y_q;
          cy_q[0] <= -b_x_q;
          ca_q[0] <= AW'(34'sd1073741824);
        end else begin
          cx_q[0] <= -b_y_q;
          cy_q[0] <= b_x_q;
          ca_q[0] <= -AW'(34'sd1073741824);
        end
      end else begin
        cx_q[0] <= b_x_q;
        cy_q[0] <= b_y_q;
        ca_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [AW-1:0] Ang = AW'(mpfc_pkg::atan_entry(5'(i)));
    logic signed [W-1:0] sx, sy;
    logic                ypos;
    assign sx   = cy_q[i] >>> i;
    assign sy   = cx_q[i] >>> i;
    assign ypos = !cy_q[i][W-1] && (cy_q[i] != '0);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cz_q[i+1] <= cz_q[i];
        if (ypos) begin
          cx_q[i+1] <= cx_q[i] + sx;
          cy_q[i+1] <= cy_q[i] - sy;
          ca_q[i+1] <= ca_q[i] + $signed(Ang);
        end else begin
          cx_q[i+1] <= cx_q[i] - sx;
          cy_q[i+1] <= cy_q[i] + sy;
          ca_q[i+1] <= ca_q[i] - $signed(Ang);
        end
      end
    end
  end

  // Round to 16 bits, saturate at both ends of the circle and give zero for a zero vector.
  logic signed [AW-1:0] hsum;
  logic signed [17:0]   hw;
  logic signed [15:0]   heading_d, heading_q;
  always_comb begin
    hsum = ca_q[N] + AW'(34'sd32768);
    hw   = hsum[AW-1:16];
    if (cz_q[N]) begin
      heading_d = '0;
    end else if (hw > 18'sd32767) begin
      heading_d = 16'sh7FFF;
    end else if (hw < -18'sd32768) begin
      heading_d = 16'sh8000;
    end else begin
      heading_d = hw[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      heading_q <= heading_d;
    end
  end

  assign heading_o = heading_q;

endmodule

`default_nettype wire

// ----- rtl/core/marker_pose_from_corners.sv -----
// ----------------------------------------------------------------------------
// Marker pose from corners
// Center, unit normal and heading of a square marker from its four corners.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+---------------------------
//   in      | input     | in_valid_i/in_stall_o | in_data_i  (four corners)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (pose)
//
// One transfer is accepted per cycle unless a held result stalls the pipeline. The
// depth is set by the bit-per-stage square root (32 stages) and the
// bit-per-stage dividers (NORMAL_FRAC_BITS + 1 stages) of the normal path.
// Reset clears only the valid bits of the pipeline; data registers are free.
// A stall at the output while a result is valid freezes the whole pipeline,
// and the input stall is raised in the same cycle, so no item is dropped or
// duplicated.
// ----------------------------------------------------------------------------
`default_nettype none

module marker_pose_from_corners #(
  parameter int NORMAL_FRAC_BITS = mpfc_pkg::NormalFracBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire mpfc_pkg::pose_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output mpfc_pkg::pose_out_t      out_data_o
);

  // Quotient bits, numerator width and the width used for saturation.
  localparam int QB  = NORMAL_FRAC_BITS + 1;
  localparam int NW  = NORMAL_FRAC_BITS + 32;
  localparam int QW  = (QB > 17) ? QB : 17;
  localparam int SQS = mpfc_pkg::SqrtSteps;
  // Register numbering: 1..7 front end, then square root, dividers and output register.
  localparam int SqLast = 7 + SQS;
  localparam int LAT    = SqLast + QB + 1;
  localparam int HDLY   = LAT - 2 - mpfc_pkg::CordicLat;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } ctr_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } flg_t;

  // The whole pipeline moves together unless the finished result is held.
  logic adv;
  logic [LAT:1] vld_q;
  assign adv        = !(vld_q[LAT] && out_stall_i);
  assign in_stall_o = !adv;
  assign out_valid_o = vld_q[LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-1:1], in_valid_i};
    end
  end

  // Stage 1: center (floor of sum over four) and the edge vectors c3-c0 and c1-c0.
  logic signed [33:0] sum_x, sum_y, sum_z;
  logic signed [32:0] e_d [3];
  logic signed [32:0] f_d [3];
  always_comb begin
    sum_x = 34'(in_data_i.c0_x) + 34'(in_data_i.c1_x)
          + 34'(in_data_i.c2_x) + 34'(in_data_i.c3_x);
    sum_y = 34'(in_data_i.c0_y) + 34'(in_data_i.c1_y)
          + 34'(in_data_i.c2_y) + 34'(in_data_i.c3_y);
    sum_z = 34'(in_data_i.c0_z) + 34'(in_data_i.c1_z)
          + 34'(in_data_i.c2_z) + 34'(in_data_i.c3_z);
    e_d[0] = 33'(in_data_i.c3_x) - 33'(in_data_i.c0_x);
    e_d[1] = 33'(in_data_i.c3_y) - 33'(in_data_i.c0_y);
    e_d[2] = 33'(in_data_i.c3_z) - 33'(in_data_i.c0_z);
    f_d[0] = 33'(in_data_i.c1_x) - 33'(in_data_i.c0_x);
    f_d[1] = 33'(in_data_i.c1_y) - 33'(in_data_i.c0_y);
    f_d[2] = 33'(in_data_i.c1_z) - 33'(in_data_i.c0_z);
  end

  logic signed [32:0] e_q [3];
  logic signed [32:0] f_q [3];
  ctr_t               ctr_q [1:LAT-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q <= e_d;
      f_q <= f_d;
      ctr_q[1].x <= 32'(sum_x >>> 2);
      ctr_q[1].y <= 32'(sum_y >>> 2);
      ctr_q[1].z <= 32'(sum_z >>> 2);
      for (int i = 2; i < LAT; i++) begin
        ctr_q[i] <= ctr_q[i-1];
      end
    end
  end

  // Heading runs beside the normal path and is delayed to line up with it.
  logic signed [15:0] hdg_w;
  logic signed [15:0] hd_q [1:HDLY];

  mpfc_cordic u_cordic (
    .clk_i     (clk_i),
    .en_i      (adv),
    .ex_i      (e_q[0]),
    .ey_i      (e_q[1]),
    .heading_o (hdg_w)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hd_q[1] <= hdg_w;
      for (int i = 2; i <= HDLY; i++) begin
        hd_q[i] <= hd_q[i-1];
      end
    end
  end

  // Stage 2: the six partial products of the cross product.
  logic signed [65:0] prd_q [6];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prd_q[0] <= e_q[1] * f_q[2];
      prd_q[1] <= e_q[2] * f_q[1];
      prd_q[2] <= e_q[2] * f_q[0];
      prd_q[3] <= e_q[0] * f_q[2];
      prd_q[4] <= e_q[0] * f_q[1];
      prd_q[5] <= e_q[1] * f_q[0];
    end
  end

  // Stage 3: exact cross product.
  logic signed [66:0] cr_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        cr_q[c] <= 67'(prd_q[2*c]) - 67'(prd_q[2*c+1]);
      end
    end
  end

  // Stage 4: magnitudes, signs and the common bit length.
  logic [66:0] mag_d [3];
  logic [66:0] mag_or;
  logic [6:0]  lmax_d;
  logic [2:0]  neg_d;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      neg_d[c] = cr_q[c][66];
      mag_d[c] = neg_d[c] ? 67'(-cr_q[c]) : 67'(cr_q[c]);
    end
    mag_or = mag_d[0] | mag_d[1] | mag_d[2];
    lmax_d = '0;
    for (int b = 0; b < 67; b++) begin
      if (mag_or[b]) begin
        lmax_d = 7'(b + 1);
      end
    end
  end

  logic [66:0] mag_q [3];
  logic [6:0]  lmax_q;
  flg_t        flg_q [4:LAT-1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q        <= mag_d;
      lmax_q       <= lmax_d;
      flg_q[4].neg   <= neg_d;
      flg_q[4].degen <= (lmax_d == '0);
      for (int i = 5; i < LAT; i++) begin
        flg_q[i] <= flg_q[i-1];
      end
    end
  end

  // Stage 5: scale so the largest magnitude lies in [2^30, 2^31).
  logic [30:0] mg_q [5:SqLast][3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        if (lmax_q > 7'd31) begin
          mg_q[5][c] <= 31'(mag_q[c] >> (lmax_q - 7'd31));
        end else begin
          mg_q[5][c] <= 31'(mag_q[c] << (7'd31 - lmax_q));
        end
      end
      for (int i = 6; i <= SqLast; i++) begin
        mg_q[i] <= mg_q[i-1];
      end
    end
  end

  // Stage 6 and 7: squares and their sum.
  logic [61:0] sq_q [3];
  logic [63:0] sumsq_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        sq_q[c] <= 62'(mg_q[5][c]) * 62'(mg_q[5][c]);
      end
      sumsq_q <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
    end
  end

  // Square root: one result bit per stage.
  logic [63:0] sr_rem_q [SQS];
  logic [63:0] sr_res_q [SQS];

  for (genvar j = 0; j < SQS; j++) begin : g_sqrt
    localparam logic [63:0] SqBit = 64'd1 << (62 - 2 * j);
    logic [63:0] rem_in, res_in;
    logic [64:0] trial;
    if (j == 0) begin : g_first
      assign rem_in = sumsq_q;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = sr_rem_q[j-1];
      assign res_in = sr_res_q[j-1];
    end
    assign trial = {1'b0, res_in} + {1'b0, SqBit};
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if ({1'b0, rem_in} >= trial) begin
          sr_rem_q[j] <= rem_in - trial[63:0];
          sr_res_q[j] <= (res_in >> 1) + SqBit;
        end else begin
          sr_rem_q[j] <= rem_in;
          sr_res_q[j] <= res_in >> 1;
        end
      end
    end
  end

  // Dividers: rounded |component| * 2^F / length, one quotient bit per stage.
  logic [31:0]   dv_den_q [QB];
  logic [31:0]   dv_rem_q [QB][3];
  logic [QB-1:0] dv_nq_q  [QB][3];
  logic [31:0]   s_len;
  assign s_len = sr_res_q[SQS-1][31:0];

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [31:0]   den_in;
    logic [31:0]   rem_in [3];
    logic [QB-1:0] nq_in  [3];
    if (k == 0) begin : g_first
      logic [NW-1:0] num [3];
      assign den_in = s_len;
      for (genvar c = 0; c < 3; c++) begin : g_num
        assign num[c]    = (NW'(mg_q[SqLast][c]) << NORMAL_FRAC_BITS) + NW'(s_len >> 1);
        assign rem_in[c] = {1'b0, num[c][NW-1:QB]};
        assign nq_in[c]  = num[c][QB-1:0];
      end
    end else begin : g_next
      assign den_in = dv_den_q[k-1];
      for (genvar c = 0; c < 3; c++) begin : g_src
        assign rem_in[c] = dv_rem_q[k-1][c];
        assign nq_in[c]  = dv_nq_q[k-1][c];
      end
    end
    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [32:0] t;
      logic        ge;
      assign t  = {rem_in[c], nq_in[c][QB-1]};
      assign ge = (t >= {1'b0, den_in});
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dv_rem_q[k][c] <= ge ? 32'(t - {1'b0, den_in}) : t[31:0];
          dv_nq_q[k][c]  <= {nq_in[c][QB-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_den_q[k] <= den_in;
      end
    end
  end

  // Output register: sign, saturation and the degenerate case.
  logic signed [15:0] nrm_d [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [QW-1:0] qx;
      qx = QW'(dv_nq_q[QB-1][c]);
      if (flg_q[LAT-1].degen) begin
        nrm_d[c] = '0;
      end else if (!flg_q[LAT-1].neg[c]) begin
        nrm_d[c] = (qx > QW'(32767)) ? 16'sh7FFF : 16'(qx);
      end else begin
        nrm_d[c] = (qx > QW'(32768)) ? 16'sh8000 : 16'(QW'(0) - qx);
      end
    end
  end

  mpfc_pkg::pose_out_t out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.center_x   <= ctr_q[LAT-1].x;
      out_q.center_y   <= ctr_q[LAT-1].y;
      out_q.center_z   <= ctr_q[LAT-1].z;
      out_q.normal_x   <= nrm_d[0];
      out_q.normal_y   <= nrm_d[1];
      out_q.normal_z   <= nrm_d[2];
      out_q.heading    <= hd_q[HDLY];
      out_q.degenerate <= flg_q[LAT-1].degen;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/mpfc_checker.sv -----
// ----------------------------------------------------------------------------
// Marker pose port checker
// Port-level checks of the marker pose pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfc_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire mpfc_pkg::pose_out_t out_data_o
);

  // A held result keeps its valid.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A held result keeps its data.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // The input is only held back by a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // A degenerate marker carries a zero normal, otherwise a nonzero one.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.normal_x == '0 && out_data_o.normal_y == '0 &&
      out_data_o.normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_normal_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.degenerate |->
      out_data_o.normal_x != '0 || out_data_o.normal_y != '0 ||
      out_data_o.normal_z != '0)
    else $error("zero normal without degenerate flag");

endmodule

bind marker_pose_from_corners mpfc_checker u_mpfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Marker pose testbench
// Drives corner sets into the marker pose pipeline with bursty input and a
// stalling output, predicts every pose in a scoreboard and checks each field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NormalBits = mpfc_pkg::NormalFracBitsDef;
  localparam int PipeDepth  = 41 + NormalBits;
  localparam int CycleLimit = 200000;

  // Scoreboard: predicts the pose of each accepted corner set and compares
  // results against the oldest outstanding prediction.
  class pose_scoreboard;
    mpfc_pkg::pose_out_t pending[$];
    int        n_errors;
    int        n_checked;
    int        n_degenerate;

    function new();
      n_errors = 0;
      n_checked = 0;
      n_degenerate = 0;
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0]  res;
      logic [127:0] t;
      res = '0;
      for (int b = 31; b >= 0; b--) begin
        t = {64'd0, res | (64'd1 << b)};
        if (t * t <= {64'd0, v}) res = res | (64'd1 << b);
      end
      return res;
    endfunction

    function logic signed [15:0] edge_heading(longint x, longint y);
      longint acc, dx, dy, t, h;
      longint unsigned m, ax, ay;
      if (x == 0 && y == 0) return 16'sd0;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      m = (ax > ay) ? ax : ay;
      acc = 0;
      while (m < (64'd1 << 33)) begin
        x = x * 2;
        y = y * 2;
        m = m << 1;
      end
      // Left half plane: turn by a quarter first so the steps converge.
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; acc = 64'sd1 <<< 30;
        end else begin
          x = -y; y = t; acc = -(64'sd1 <<< 30);
        end
      end
      for (int i = 0; i < mpfc_pkg::CordicSteps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx; y = y - dy;
          acc = acc + longint'(mpfc_pkg::atan_entry(i[4:0]));
        end else begin
          x = x - dx; y = y + dy;
          acc = acc - longint'(mpfc_pkg::atan_entry(i[4:0]));
        end
      end
      h = (acc + 32768) >>> 16;
      if (h > 32767) h = 32767;
      if (h < -32768) h = -32768;
      return h[15:0];
    endfunction

    function mpfc_pkg::pose_out_t predict_pose(mpfc_pkg::pose_in_t p);
      mpfc_pkg::pose_out_t  r;
      longint               c[12];
      longint               e[3], f[3], sum;
      logic signed [127:0]  ee[3], ff[3], cr[3];
      logic [127:0]         mg_full[3];
      logic [63:0]          mg[3], sumsq, s, q;
      logic                 neg[3];
      longint               v;
      int                   lmax;
      c = '{p.c0_x, p.c0_y, p.c0_z, p.c1_x, p.c1_y, p.c1_z,
            p.c2_x, p.c2_y, p.c2_z, p.c3_x, p.c3_y, p.c3_z};
      for (int i = 0; i < 3; i++) begin
        sum = c[i] + c[3+i] + c[6+i] + c[9+i];
        sum = sum >>> 2;
        if (i == 0) r.center_x = sum[31:0];
        if (i == 1) r.center_y = sum[31:0];
        if (i == 2) r.center_z = sum[31:0];
        e[i] = c[9+i] - c[i];
        f[i] = c[3+i] - c[i];
        ee[i] = 128'(e[i]);
        ff[i] = 128'(f[i]);
      end
      cr[0] = ee[1] * ff[2] - ee[2] * ff[1];
      cr[1] = ee[2] * ff[0] - ee[0] * ff[2];
      cr[2] = ee[0] * ff[1] - ee[1] * ff[0];
      lmax = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = cr[i] < 0;
        mg_full[i] = neg[i] ? -cr[i] : cr[i];
        for (int b = 127; b >= 0; b--) begin
          if (mg_full[i][b]) begin
            if (b + 1 > lmax) lmax = b + 1;
            break;
          end
        end
      end
      if (lmax == 0) begin
        // Collinear or coincident edges: no plane, so the normal is zeroed.
        r.normal_x = '0;
        r.normal_y = '0;
        r.normal_z = '0;
        r.degenerate = 1'b1;
      end else begin
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
          if (lmax > 31) mg[i] = 64'(mg_full[i] >> (lmax - 31));
          else mg[i] = 64'(mg_full[i] << (31 - lmax));
          sumsq = sumsq + mg[i] * mg[i];
        end
        s = floor_sqrt(sumsq);
        for (int i = 0; i < 3; i++) begin
          q = ((mg[i] << NormalBits) + (s >> 1)) / s;
          v = neg[i] ? -longint'(q) : longint'(q);
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          if (i == 0) r.normal_x = v[15:0];
          if (i == 1) r.normal_y = v[15:0];
          if (i == 2) r.normal_z = v[15:0];
        end
        r.degenerate = 1'b0;
      end
      r.heading = edge_heading(e[0], e[1]);
      return r;
    endfunction

    function void note_corners(mpfc_pkg::pose_in_t p);
      pending = {pending, predict_pose(p)};
    endfunction

    function void check_pose(mpfc_pkg::pose_out_t got);
      mpfc_pkg::pose_out_t want;
      if (pending.size() == 0) begin
        $error("pose transfer with no corner set outstanding");
        n_errors++;
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (want.degenerate) n_degenerate++;
      if (got.center_x !== want.center_x) begin
        $error("center_x: expected %0d, got %0d", want.center_x, got.center_x); n_errors++;
      end
      if (got.center_y !== want.center_y) begin
        $error("center_y: expected %0d, got %0d", want.center_y, got.center_y); n_errors++;
      end
      if (got.center_z !== want.center_z) begin
        $error("center_z: expected %0d, got %0d", want.center_z, got.center_z); n_errors++;
      end
      if (got.normal_x !== want.normal_x) begin
        $error("normal_x: expected %0d, got %0d", want.normal_x, got.normal_x); n_errors++;
      end
      if (got.normal_y !== want.normal_y) begin
        $error("normal_y: expected %0d, got %0d", want.normal_y, got.normal_y); n_errors++;
      end
      if (got.normal_z !== want.normal_z) begin
        $error("normal_z: expected %0d, got %0d", want.normal_z, got.normal_z); n_errors++;
      end
      if (got.heading !== want.heading) begin
        $error("heading: expected %0d, got %0d", want.heading, got.heading); n_errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $error("degenerate: expected %0b, got %0b", want.degenerate, got.degenerate);
        n_errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mpfc_pkg::pose_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mpfc_pkg::pose_out_t out_data;

  pose_scoreboard board = new();
  int unsigned    cycles = 0;
  bit             stimulus_done = 1'b0;

  always #5 clk_i = ~clk_i;

  marker_pose_from_corners #(
    .NORMAL_FRAC_BITS(NormalBits)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // Both monitors sample at the rising edge, before the edge's own updates
  // land, so a transfer is seen exactly as the block sees it.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) board.note_corners(in_data);
    if (rst_ni && out_valid && !out_stall) board.check_pose(out_data);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offers one corner set and holds it until the transfer happens. Back to
  // back calls keep valid high, so a burst has no bubbles.
  task automatic offer_corners(mpfc_pkg::pose_in_t p);
    in_data  <= p;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic idle_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Builds a corner set from an origin and the edge vectors u and v, with c2 placed
  // opposite c0 as on a real marker.
  function automatic mpfc_pkg::pose_in_t square_from(
      longint ox, longint oy, longint oz,
      longint ux, longint uy, longint uz,
      longint vx, longint vy, longint vz);
    mpfc_pkg::pose_in_t p;
    p.c0_x = 32'(ox);           p.c0_y = 32'(oy);           p.c0_z = 32'(oz);
    p.c1_x = 32'(ox + ux);      p.c1_y = 32'(oy + uy);      p.c1_z = 32'(oz + uz);
    p.c2_x = 32'(ox + ux + vx); p.c2_y = 32'(oy + uy + vy); p.c2_z = 32'(oz + uz + vz);
    p.c3_x = 32'(ox + vx);      p.c3_y = 32'(oy + vy);      p.c3_z = 32'(oz + vz);
    return p;
  endfunction

  function automatic longint small_coord(int span);
    return longint'($urandom_range(2 * span)) - span;
  endfunction

  function automatic mpfc_pkg::pose_in_t random_corners();
    mpfc_pkg::pose_in_t p;
    int                 kind;
    kind = $urandom_range(9);
    if (kind < 3) begin
      // Fully random words: every bit of every field toggles.
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (kind < 8) begin
      // A plausible marker: modest origin and edges of random size.
      p = square_from(small_coord(1 << 24), small_coord(1 << 24), small_coord(1 << 24),
                      small_coord(1 << 20), small_coord(1 << 20), small_coord(1 << 20),
                      small_coord(1 << 20), small_coord(1 << 20), small_coord(1 << 20));
    end else if (kind == 8) begin
      // Tiny edges exercise the heading normalization and small products.
      p = square_from(small_coord(1 << 30), small_coord(1 << 30), small_coord(1 << 30),
                      small_coord(3), small_coord(3), small_coord(3),
                      small_coord(3), small_coord(3), small_coord(3));
    end else begin
      // Parallel edges give a degenerate plane.
      p = square_from(small_coord(1 << 20), small_coord(1 << 20), small_coord(1 << 20),
                      2 * small_coord(1 << 10), 2 * small_coord(1 << 10), 0,
                      0, 0, 0);
      p.c3_x = p.c0_x + (p.c1_x - p.c0_x) / 2;
      p.c3_y = p.c0_y + (p.c1_y - p.c0_y) / 2;
      p.c3_z = p.c0_z;
    end
    return p;
  endfunction

  // Receiver: stall density changes per segment, including segments with no
  // stall at all. One long hold-off lets the pipeline fill and push back.
  initial begin
    int density;
    int span;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && cycles > 200) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (4 * PipeDepth) @(posedge clk_i);
      end
      density = $urandom_range(3) * 30;
      span = $urandom_range(60, 5);
      repeat (span) begin
        out_stall <= ($urandom_range(99) < density);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    mpfc_pkg::pose_in_t p;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner sets.
    offer_corners('0);  // all corners coincide: degenerate, zero edge
    offer_corners({12{32'h7FFF_FFFF}});
    offer_corners({12{32'h8000_0000}});
    p = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    offer_corners(p);  // widest edges, largest cross product
    offer_corners(square_from(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
    offer_corners(square_from(0, 0, 0, 0, 65536, 0, 65536, 0, 0));
    offer_corners(square_from(100, 200, 300, 0, 0, 65536, -65536, 0, 0));  // heading pi
    offer_corners(square_from(5, 5, 5, 0, 0, 65536, -65536, -1, 0));  // just above -pi
    offer_corners(square_from(5, 5, 5, 0, 0, 65536, -65536, 1, 0));   // just below pi
    offer_corners(square_from(0, 0, 0, 65536, 0, 0, 0, -65536, 0));   // straight down
    offer_corners(square_from(-7, 3, 9, 1, 0, 0, 0, 1, 0));            // unit edges
    offer_corners(square_from(1, 1, 1, 0, 0, 1, 0, 0, 0));             // zero edge c3-c0
    offer_corners(square_from(0, 0, 0, 2, 2, 2, 1, 1, 1));             // parallel edges
    offer_corners(square_from(-1, -1, -1, 0, 0, -3, -3, 3, 0));        // floored center
    offer_corners(square_from(0, 0, 0, 1, 0, 0, 0, 0, 1));             // normal along +y
    idle_input(3);

    // Random corner sets in bursts with random gaps; a gap may be empty.
    for (int n = 0; n < 400; ) begin
      int burst;
      burst = $urandom_range(20, 1);
      for (int k = 0; k < burst && n < 400; k++, n++) offer_corners(random_corners());
      idle_input($urandom_range(3) == 0 ? 0 : $urandom_range(8));
    end

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (2 * PipeDepth) @(posedge clk_i);
    $display("checked %0d poses, %0d of them degenerate, under bursty input",
             board.n_checked, board.n_degenerate);
    $display("and random output stalls with one long hold-off");
    if (board.n_errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- marker_pose_from_corners.f -----
rtl/core/mpfc_pkg.sv
rtl/core/mpfc_cordic.sv
rtl/core/marker_pose_from_corners.sv
rtl/core/mpfc_checker.sv
tb/sv/tb.sv
